/* rtl/core/rgbfx_pkg.sv */
// ----------------------------------------------------------------------------
// rgbfx_pkg
// Shared types, codes and constant tables of the RGB LED effect generator.
// ----------------------------------------------------------------------------
package rgbfx_pkg;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_JUMP    = 3'd1,
        MODE_STROBE  = 3'd2,
        MODE_GRADUAL = 3'd3,
        MODE_SMOOTH  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_JUMP    = 2'd0,
        REG_GRADUAL = 2'd1,
        REG_SMOOTH  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam logic [15:0] JUMP_INTERVAL_RST    = 16'd1000;
    localparam logic [15:0] GRADUAL_INTERVAL_RST = 16'd20;
    localparam logic [15:0] SMOOTH_INTERVAL_RST  = 16'd10;

    localparam int          COLOR_SLOTS = 7;
    localparam logic [2:0]  SLOT_LAST   = 3'(COLOR_SLOTS - 1);

    // Half-degree sine: 720 entries per turn, built from one quadrant of 181.
    localparam logic [10:0] SINE_TURN    = 11'd720;
    localparam logic [10:0] SINE_TURN2   = 11'd1440;
    localparam logic [10:0] SINE_HALF    = 11'd360;
    localparam logic [8:0]  SINE_QUARTER = 9'd180;
    localparam logic [8:0]  SINE_HALF9   = 9'd360;
    localparam logic [10:0] GREEN_OFFSET = 11'd240;
    localparam logic [10:0] BLUE_OFFSET  = 11'd480;

    localparam real PI = 3.14159265358979323846;

    typedef logic [7:0] sine_tbl_t [0:180];

    function automatic sine_tbl_t build_sine_tbl(input bit lower);
        sine_tbl_t tbl;
        real       s;
        real       v;
        for (int j = 0; j <= 180; j++)
        begin
            s = $sin(real'(j) * PI / 360.0);
            v = lower ? (127.5 - 127.5 * s) : (127.5 + 127.5 * s);
            tbl[j] = 8'(int'($floor(v)));
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_UPPER = build_sine_tbl(1'b0);
    localparam sine_tbl_t SINE_LOWER = build_sine_tbl(1'b1);

    function automatic rgb_t jump_color(input logic [2:0] slot);
        rgb_t c;
        unique case (slot)
            3'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd2:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            3'd4:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            3'd5:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            3'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/rgbfx_wave.sv */
// ----------------------------------------------------------------------------
// rgbfx_wave
// Three-phase sine lookup: one wave step in, red/green/blue 120 degrees apart.
// ----------------------------------------------------------------------------
module rgbfx_wave #(
    parameter int STEP_W = 9
) (
    input  logic [STEP_W-1:0] step,
    output rgbfx_pkg::rgb_t   color
);
    import rgbfx_pkg::*;

    function automatic logic [7:0] sine_at(input logic [10:0] k_raw);
        logic [10:0] k;
        logic        lower;
        logic [8:0]  m;
        logic [8:0]  j9;
        logic [7:0]  j;
        if (k_raw >= SINE_TURN2)
        begin
            k = k_raw - SINE_TURN2;
        end
        else if (k_raw >= SINE_TURN)
        begin
            k = k_raw - SINE_TURN;
        end
        else
        begin
            k = k_raw;
        end
        lower = (k >= SINE_HALF);
        m     = lower ? 9'(k - SINE_HALF) : 9'(k);
        j9    = (m <= SINE_QUARTER) ? m : (SINE_HALF9 - m);
        j     = j9[7:0];
        return lower ? SINE_LOWER[j] : SINE_UPPER[j];
    endfunction

    logic [10:0] step_ext;

    assign step_ext    = 11'(step);
    assign color.red   = sine_at(step_ext);
    assign color.green = sine_at(step_ext + GREEN_OFFSET);
    assign color.blue  = sine_at(step_ext + BLUE_OFFSET);

endmodule

/* rtl/core/rgb_led_effect_generator_unit.sv */
// ----------------------------------------------------------------------------
// rgb_led_effect_generator_unit
// RGB LED effect sequencer: off, color jump, strobe and two sine-wave modes.
// ----------------------------------------------------------------------------
// Takes one transfer (mode, now_ms) per clock unless in_stall is high and
// yields at most one color transfer per input. An input passes through an
// input register and then a single pass of logic (elapsed-time compare,
// color table or sine table lookup, strobe parity by reciprocal multiply)
// into the result register. The throughput is one item per cycle; it drops
// only while out_stall holds a waiting result. Inputs that produce no color
// (jump and wave modes before their interval has passed) still advance the
// effect state. Interval registers are written over the APB port at 0x0,
// 0x4 and 0x8 and should change only while idle.
// ----------------------------------------------------------------------------
module rgb_led_effect_generator_unit #(
    parameter int STROBE_MS  = 250,
    parameter int WAVE_STEPS = 360
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgbfx_pkg::*;

    localparam int              STEP_W      = (WAVE_STEPS > 1) ? $clog2(WAVE_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WAVE_STEPS - 1);
    localparam int              STROBE_SH   = $clog2(STROBE_MS);
    localparam logic [63:0]     STROBE_MUL64 =
        ((64'd1 << (32 + STROBE_SH)) + 64'(STROBE_MS) - 64'd1) / 64'(STROBE_MS);
    localparam logic [32:0]     STROBE_MUL  = STROBE_MUL64[32:0];
    localparam logic [31:0]     STROBE_LEN  = 32'(STROBE_MS);

    // configuration
    logic [15:0] jump_interval_reg;
    logic [15:0] gradual_interval_reg;
    logic [15:0] smooth_interval_reg;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_interval_reg    <= JUMP_INTERVAL_RST;
            gradual_interval_reg <= GRADUAL_INTERVAL_RST;
            smooth_interval_reg  <= SMOOTH_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_JUMP:    jump_interval_reg    <= pwdata[15:0];
                REG_GRADUAL: gradual_interval_reg <= pwdata[15:0];
                REG_SMOOTH:  smooth_interval_reg  <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_JUMP:    prdata = {16'd0, jump_interval_reg};
            REG_GRADUAL: prdata = {16'd0, gradual_interval_reg};
            REG_SMOOTH:  prdata = {16'd0, smooth_interval_reg};
            default:     prdata = '0;
        endcase
    end

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_mode_reg;
    logic [31:0] s1_now_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    rgb_t        out_color_reg;
    logic        advance;
    logic        in_take;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || advance)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_now_reg  <= now_ms;
        end
    end

    // effect state
    logic [2:0]        active_mode_reg;
    logic [31:0]       last_update_ms_reg;
    logic [2:0]        color_slot_reg;
    logic [STEP_W-1:0] wave_step_reg;

    logic [31:0]       last_update_ms_next;
    logic [2:0]        color_slot_next;
    logic [STEP_W-1:0] wave_step_next;

    logic              mode_change;
    logic [31:0]       elapsed;
    logic [31:0]       last_base;
    logic [2:0]        slot_base;
    logic [STEP_W-1:0] step_base;
    logic [STEP_W-1:0] step_adv;
    logic [15:0]       wave_interval;
    logic              jump_due;
    logic              strobe_due;
    logic              wave_due;
    logic [64:0]       strobe_prod;
    logic              strobe_odd;
    logic [7:0]        strobe_lvl;
    rgb_t              wave_color;
    rgb_t              result_color;
    logic              has_result;

    assign mode_change   = (s1_mode_reg != active_mode_reg);
    assign last_base     = mode_change ? s1_now_reg : last_update_ms_reg;
    assign slot_base     = mode_change ? 3'd0 : color_slot_reg;
    assign step_base     = mode_change ? '0 : wave_step_reg;
    assign elapsed       = s1_now_reg - last_base;
    assign wave_interval = (s1_mode_reg == MODE_GRADUAL) ? gradual_interval_reg
                                                         : smooth_interval_reg;
    assign jump_due      = (elapsed >= {16'd0, jump_interval_reg});
    assign wave_due      = (elapsed >= {16'd0, wave_interval});
    assign strobe_due    = (elapsed >= STROBE_LEN);
    assign step_adv      = (step_base == STEP_LAST) ? '0 : step_base + 1'b1;
    assign strobe_prod   = 65'(s1_now_reg) * 65'(STROBE_MUL);
    assign strobe_odd    = strobe_prod[32 + STROBE_SH];
    assign strobe_lvl    = strobe_odd ? 8'd0 : 8'd255;

    rgbfx_wave #(
        .STEP_W (STEP_W)
    ) u_wave (
        .step  (step_adv),
        .color (wave_color)
    );

    always_comb
    begin
        last_update_ms_next = last_base;
        color_slot_next     = slot_base;
        wave_step_next      = step_base;
        has_result          = 1'b0;
        result_color        = '0;
        unique case (s1_mode_reg)
            MODE_JUMP:
            begin
                if (jump_due)
                begin
                    last_update_ms_next = s1_now_reg;
                    color_slot_next     = (slot_base == SLOT_LAST) ? 3'd0 : slot_base + 3'd1;
                    has_result          = 1'b1;
                    result_color        = jump_color(slot_base);
                end
            end
            MODE_STROBE:
            begin
                if (strobe_due)
                begin
                    last_update_ms_next = s1_now_reg;
                end
                has_result   = 1'b1;
                result_color = '{red: strobe_lvl, green: strobe_lvl, blue: strobe_lvl};
            end
            MODE_GRADUAL, MODE_SMOOTH:
            begin
                if (wave_due)
                begin
                    last_update_ms_next = s1_now_reg;
                    wave_step_next      = step_adv;
                    has_result          = 1'b1;
                    result_color        = wave_color;
                end
            end
            default:
            begin
                has_result = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mode_reg    <= MODE_OFF;
            last_update_ms_reg <= '0;
            color_slot_reg     <= '0;
            wave_step_reg      <= '0;
        end
        else if (advance)
        begin
            active_mode_reg    <= s1_mode_reg;
            last_update_ms_reg <= last_update_ms_next;
            color_slot_reg     <= color_slot_next;
            wave_step_reg      <= wave_step_next;
        end
    end

    // result register
    assign out_valid_next = advance ? has_result : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_color_reg <= result_color;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_color_reg.red;
    assign green     = out_color_reg.green;
    assign blue      = out_color_reg.blue;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        color_slot_reg <= SLOT_LAST)
        else $error("color slot out of range");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        wave_step_reg <= STEP_LAST)
        else $error("wave step out of range");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked item");

    a_strobe_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_mode_reg == MODE_STROBE) |=> out_valid_reg)
        else $error("strobe item produced no color");

    a_restart_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_change) |=> (last_update_ms_reg == $past(s1_now_reg)))
        else $error("mode change did not restart the timer");

endmodule
